[hw/rtl/sypg_pkg.sv]
// Shared types and constants for the y-gap point segmentation block.
package sypg_pkg;

    // Widths fixed by the point format
    localparam int unsigned COORD_W  = 32;
    localparam int unsigned COLOR_W  = 24;
    localparam int unsigned REGION_W = 6;
    localparam logic [REGION_W-1:0] REGION_MAX = {REGION_W{1'b1}};

    // Controller state codes
    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SETTLE = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;

    // One stored point
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic        [COLOR_W-1:0] color;
    } point_t;

    // A point with its occupancy mark, as held in or moved along the chain;
    // displaced marks a point pushed out of its cell by an arriving point
    typedef struct packed {
        logic   valid;
        logic   displaced;
        point_t pt;
    } cell_word_t;

endpackage

[hw/rtl/sypg_if.sv]
// Stream interfaces for incoming points and emitted segmented points.
interface sypg_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sypg_pkg::COORD_W-1:0]  x_pos;
    logic signed [sypg_pkg::COORD_W-1:0]  y_pos;
    logic signed [sypg_pkg::COORD_W-1:0]  z_pos;
    logic        [sypg_pkg::COLOR_W-1:0]  color;
    logic                                 final_point;

    modport source (output valid, x_pos, y_pos, z_pos, color, final_point, input ready);
    modport sink   (input valid, x_pos, y_pos, z_pos, color, final_point, output ready);
endinterface

interface sypg_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sypg_pkg::COORD_W-1:0]  out_x;
    logic signed [sypg_pkg::COORD_W-1:0]  out_y;
    logic signed [sypg_pkg::COORD_W-1:0]  out_z;
    logic        [sypg_pkg::COLOR_W-1:0]  out_color;
    logic        [sypg_pkg::REGION_W-1:0] region;
    logic                                 overflowed;
    logic                                 last_out;

    modport source (output valid, out_x, out_y, out_z, out_color, region, overflowed,
                    last_out, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_color, region, overflowed,
                    last_out, output ready);
endinterface

[hw/rtl/sypg_cell.sv]
// One cell of the insertion chain: holds one point and passes the larger one on.
module sypg_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift,      // drain: take the right neighbor's point
    input  sypg_pkg::cell_word_t travel_in,  // point arriving from the left
    input  sypg_pkg::cell_word_t shift_in,   // right neighbor's stored point
    output sypg_pkg::cell_word_t stored,
    output sypg_pkg::cell_word_t travel_out  // point handed to the right
);

    logic                 stored_valid_reg;
    sypg_pkg::point_t     stored_pt_reg;
    logic                 travel_valid_reg;
    logic                 travel_displaced_reg;
    sypg_pkg::point_t     travel_pt_reg;
    sypg_pkg::cell_word_t stored_cur, stored_next;
    sypg_pkg::cell_word_t travel_cur, travel_next;
    logic                 take_new;

    // Assemble the held words
    always_comb
    begin
        stored_cur.valid     = stored_valid_reg;
        stored_cur.displaced = 1'b0;
        stored_cur.pt        = stored_pt_reg;
        travel_cur.valid     = travel_valid_reg;
        travel_cur.displaced = travel_displaced_reg;
        travel_cur.pt        = travel_pt_reg;
    end

    // Keep the smaller y; a new point stays behind an equal one, while a
    // displaced point is older than any equal point further on and claims the cell
    assign take_new = !stored_cur.valid
                   || ($signed(travel_in.pt.y) < $signed(stored_cur.pt.y))
                   || (travel_in.displaced
                       && ($signed(travel_in.pt.y) == $signed(stored_cur.pt.y)));

    always_comb
    begin
        stored_next       = stored_cur;
        travel_next       = travel_cur;
        travel_next.valid = 1'b0;
        if (shift)
        begin
            stored_next = shift_in;
        end
        else if (travel_in.valid)
        begin
            if (take_new)
            begin
                stored_next           = travel_in;
                travel_next           = stored_cur;
                travel_next.displaced = 1'b1;
            end
            else
            begin
                travel_next = travel_in;
            end
        end
    end

    // Hold occupancy under reset; payload needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_valid_reg <= 1'b0;
            travel_valid_reg <= 1'b0;
        end
        else
        begin
            stored_valid_reg <= stored_next.valid;
            travel_valid_reg <= travel_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stored_pt_reg        <= stored_next.pt;
        travel_pt_reg        <= travel_next.pt;
        travel_displaced_reg <= travel_next.displaced;
    end

    assign stored     = stored_cur;
    assign travel_out = travel_cur;

endmodule

[hw/rtl/segment_points_by_y_gap_top.sv]
// Top level of the y-gap point segmentation block: insertion chain and emitter.
//
// Points enter at one word per cycle and ripple through a chain of MAX_POINTS
// cells, one cell per cycle, so the chain stays sorted by y (ties in arrival
// order). After the word marked final_point the block waits for the last point
// to settle, then shifts the chain out of cell 0 at one word per cycle while
// the sink accepts, through a single output register, numbering regions where
// the y step exceeds the threshold written through cfg_wdata. Input ready is
// low from the final point until the last result is loaded into the output
// register. Points beyond MAX_POINTS are dropped and reported through
// overflowed on every result of that cloud.
module segment_points_by_y_gap_top #(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    sypg_point_if.sink          points,
    sypg_result_if.source       results
);

    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_POINTS);
    localparam logic [CNT_W-1:0] SETTLE_LAST = CNT_W'(MAX_POINTS - 1);

    // Control registers
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] settle_reg, settle_next;
    logic             overflow_reg, overflow_next;
    logic             first_reg, first_next;
    logic [31:0]      thr_reg;
    logic             out_valid_reg, out_valid_next;

    // Output payload registers
    sypg_pkg::point_t              out_pt_reg;
    logic [sypg_pkg::REGION_W-1:0] region_reg, region_next;
    logic                          out_ovf_reg;
    logic                          out_last_reg;

    // Chain wiring
    sypg_pkg::cell_word_t stored_w [MAX_POINTS];
    sypg_pkg::cell_word_t travel_w [MAX_POINTS];
    sypg_pkg::cell_word_t entry_w;
    sypg_pkg::cell_word_t empty_w;

    logic accept, store_it, out_free, emit;
    logic [32:0] dy;
    logic        gap;

    assign points.ready = (state_reg == sypg_pkg::ST_LOAD);
    assign accept       = points.valid && points.ready;
    assign store_it     = accept && (count_reg < CNT_MAX);
    assign out_free     = !out_valid_reg || results.ready;
    assign emit         = (state_reg == sypg_pkg::ST_DRAIN) && out_free;

    // Feed the new point into cell 0
    always_comb
    begin
        entry_w.valid     = store_it;
        entry_w.displaced = 1'b0;
        entry_w.pt.x      = points.x_pos;
        entry_w.pt.y      = points.y_pos;
        entry_w.pt.z      = points.z_pos;
        entry_w.pt.color  = points.color;
        empty_w           = '0;
    end

    // Build the chain
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        sypg_pkg::cell_word_t t_in, s_in;
        if (i == 0)
        begin : g_head
            assign t_in = entry_w;
        end
        else
        begin : g_body
            assign t_in = travel_w[i-1];
        end
        if (i == MAX_POINTS - 1)
        begin : g_tail
            assign s_in = empty_w;
        end
        else
        begin : g_inner
            assign s_in = stored_w[i+1];
        end
        sypg_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (emit),
            .travel_in  (t_in),
            .shift_in   (s_in),
            .stored     (stored_w[i]),
            .travel_out (travel_w[i])
        );
    end

    // Y step from the previous emitted point; sorted order keeps it non-negative
    assign dy  = {stored_w[0].pt.y[31], stored_w[0].pt.y}
               - {out_pt_reg.y[31], out_pt_reg.y};
    assign gap = dy > {1'b0, thr_reg};

    // Sequence load, settle and drain
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        settle_next    = settle_reg;
        overflow_next  = overflow_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg;
        region_next    = region_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            sypg_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    if (store_it)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (points.final_point)
                    begin
                        state_next  = sypg_pkg::ST_SETTLE;
                        settle_next = '0;
                    end
                end
            end
            sypg_pkg::ST_SETTLE:
            begin
                settle_next = settle_reg + 1'b1;
                if (settle_reg == SETTLE_LAST)
                begin
                    state_next = sypg_pkg::ST_DRAIN;
                    first_next = 1'b1;
                end
            end
            sypg_pkg::ST_DRAIN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    first_next     = 1'b0;
                    count_next     = count_reg - 1'b1;
                    if (first_reg)
                    begin
                        region_next = '0;
                    end
                    else if (gap && (region_reg != sypg_pkg::REGION_MAX))
                    begin
                        region_next = region_reg + 1'b1;
                    end
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next    = sypg_pkg::ST_LOAD;
                        overflow_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = sypg_pkg::ST_LOAD;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sypg_pkg::ST_LOAD;
            count_reg     <= '0;
            settle_reg    <= '0;
            overflow_reg  <= 1'b0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            thr_reg       <= 32'd65536;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            settle_reg    <= settle_next;
            overflow_reg  <= overflow_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    // Load the output word from cell 0
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_pt_reg   <= stored_w[0].pt;
            region_reg   <= region_next;
            out_ovf_reg  <= overflow_reg;
            out_last_reg <= (count_reg == CNT_W'(1));
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.out_x      = out_pt_reg.x;
    assign results.out_y      = out_pt_reg.y;
    assign results.out_z      = out_pt_reg.z;
    assign results.out_color  = out_pt_reg.color;
    assign results.region     = region_reg;
    assign results.overflowed = out_ovf_reg;
    assign results.last_out   = out_last_reg;

endmodule

[hw/rtl/sypg_checker.sv]
// Port-level checks for the y-gap segmentation block, bound to the top level.
module sypg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [sypg_pkg::COORD_W-1:0] out_y,
    input logic [sypg_pkg::REGION_W-1:0]     region,
    input logic                              overflowed,
    input logic                              last_out
);

    // A pending result word stays until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result word dropped before it was taken");

    // Input is closed while a cloud is still being emitted
    a_no_input_mid_cloud: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last_out) |-> !in_ready)
        else $error("input open in the middle of a cloud");

    // Region steps by zero or one within a cloud
    a_region_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_out) |=>
            (region == $past(region)) || (region == $past(region) + 1'b1))
        else $error("region index jumped");

    // Y never falls and the overflow flag never changes within a cloud
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_out) |=>
            (out_y >= $past(out_y)) && (overflowed == $past(overflowed)))
        else $error("emitted points out of order or overflow flag changed");

endmodule

bind segment_points_by_y_gap_top sypg_checker u_sypg_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (points.ready),
    .out_valid  (results.valid),
    .out_ready  (results.ready),
    .out_y      (results.out_y),
    .region     (results.region),
    .overflowed (results.overflowed),
    .last_out   (results.last_out)
);

[sim/sypg_segment_checker.sv]
// Stream checker for the y-gap segmentation block: predicts sorted, segmented points.
module sypg_segment_checker #(
    parameter int unsigned MAX_POINTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    sypg_point_if       points,
    sypg_result_if      results,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // One predicted output word
    typedef struct packed {
        sypg_pkg::point_t                pt;
        logic [sypg_pkg::REGION_W-1:0]   region;
        logic                            overflowed;
        logic                            last_out;
    } seg_word_t;

    sypg_pkg::point_t cloud_pts [MAX_POINTS];
    int unsigned cloud_count;
    bit          cloud_dropped;
    logic [31:0] gap_limit;
    seg_word_t   segmented_q [$];
    int unsigned reported;

    // Log a failure; print only the first few in detail
    function automatic void flag_failure(input string what, input seg_word_t want,
                                         input seg_word_t got);
        mismatches++;
        if (reported < 10) begin
            reported++;
            $display("%0t ns: %s", $time, what);
            $display("    expected x=%h y=%h z=%h color=%h region=%0d ovf=%b last=%b",
                     want.pt.x, want.pt.y, want.pt.z, want.pt.color, want.region,
                     want.overflowed, want.last_out);
            $display("    actual   x=%h y=%h z=%h color=%h region=%0d ovf=%b last=%b",
                     got.pt.x, got.pt.y, got.pt.z, got.pt.color, got.region,
                     got.overflowed, got.last_out);
        end
    endfunction

    // Store a point (or drop it when full); on the final point sort and segment
    function automatic void take_point(input sypg_pkg::point_t p, input logic fin);
        int unsigned order [MAX_POINTS];
        int          j;
        logic [sypg_pkg::REGION_W-1:0] region;
        longint      step;
        seg_word_t   word;
        if (cloud_count < MAX_POINTS) begin
            cloud_pts[cloud_count] = p;
            cloud_count++;
        end
        else begin
            cloud_dropped = 1'b1;
        end
        if (fin) begin
            // stable insertion sort on signed y: ties keep arrival order
            for (int i = 0; i < int'(cloud_count); i++) begin
                j = i;
                while (j > 0 && $signed(cloud_pts[order[j-1]].y) > $signed(cloud_pts[i].y)) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            // number regions where the y step exceeds the threshold
            region = '0;
            for (int i = 0; i < int'(cloud_count); i++) begin
                if (i > 0) begin
                    step = longint'($signed(cloud_pts[order[i]].y))
                         - longint'($signed(cloud_pts[order[i-1]].y));
                    if (step > longint'({32'd0, gap_limit}) && region != sypg_pkg::REGION_MAX)
                        region++;
                end
                word.pt         = cloud_pts[order[i]];
                word.region     = region;
                word.overflowed = cloud_dropped;
                word.last_out   = (i == int'(cloud_count) - 1);
                segmented_q.insert(segmented_q.size(), word);
            end
            cloud_count   = 0;
            cloud_dropped = 1'b0;
        end
    endfunction

    // Compare one emitted word with the oldest prediction, field by field
    function automatic void check_word(input seg_word_t got);
        seg_word_t want;
        string     bad;
        if (segmented_q.size() == 0) begin
            flag_failure("result word with no prediction pending", '0, got);
            return;
        end
        want = segmented_q.pop_front();
        bad  = "";
        if (want.pt.x !== got.pt.x)         bad = {bad, " out_x"};
        if (want.pt.y !== got.pt.y)         bad = {bad, " out_y"};
        if (want.pt.z !== got.pt.z)         bad = {bad, " out_z"};
        if (want.pt.color !== got.pt.color) bad = {bad, " out_color"};
        if (want.region !== got.region)     bad = {bad, " region"};
        if (want.overflowed !== got.overflowed) bad = {bad, " overflowed"};
        if (want.last_out !== got.last_out) bad = {bad, " last_out"};
        if (bad != "")
            flag_failure({"result word mismatch in", bad}, want, got);
    endfunction

    // Watch config, result and point channels at every edge
    always @(posedge clk or negedge rst_n) begin
        sypg_pkg::point_t p;
        seg_word_t got;
        if (!rst_n) begin
            cloud_count   = 0;
            cloud_dropped = 1'b0;
            gap_limit     = 32'd65536;
            segmented_q.delete();
            mismatches    = 0;
            reported      = 0;
            outstanding  <= 0;
        end
        else begin
            if (cfg_we)
                gap_limit = cfg_wdata;
            if (results.valid === 1'b1 && results.ready === 1'b1) begin
                got.pt.x       = results.out_x;
                got.pt.y       = results.out_y;
                got.pt.z       = results.out_z;
                got.pt.color   = results.out_color;
                got.region     = results.region;
                got.overflowed = results.overflowed;
                got.last_out   = results.last_out;
                check_word(got);
            end
            if (points.valid === 1'b1 && points.ready === 1'b1) begin
                p.x     = points.x_pos;
                p.y     = points.y_pos;
                p.z     = points.z_pos;
                p.color = points.color;
                take_point(p, points.final_point);
            end
            outstanding <= segmented_q.size();
        end
    end

endmodule

[sim/tb_top.sv]
// Testbench top for the y-gap segmentation block: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_POINTS    = 64;
    localparam int unsigned TEST_ITEMS    = 370;
    localparam int unsigned SETTLE_CYCLES = MAX_POINTS + 8;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned items_sent;
    int unsigned cycle_count;

    sypg_point_if  pts ();
    sypg_result_if res ();

    segment_points_by_y_gap_top #(
        .MAX_POINTS (MAX_POINTS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .points    (pts),
        .results   (res)
    );

    sypg_segment_checker #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seg_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .points      (pts),
        .results     (res),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Draw the idle cycles before the next word; alternate busy and calm stretches
    function automatic int unsigned pace(inout bit calm, inout int unsigned left);
        if (left == 0) begin
            calm = ($urandom_range(0, 2) == 0);
            left = $urandom_range(8, 48);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    bit          send_calm;
    int unsigned send_left;

    // Present one point and hold it until accepted
    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z, input logic [23:0] color,
                              input bit fin);
        int unsigned gap;
        gap = pace(send_calm, send_left);
        if (gap != 0) begin
            pts.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pts.valid       <= 1'b1;
        pts.x_pos       <= x;
        pts.y_pos       <= y;
        pts.z_pos       <= z;
        pts.color       <= color;
        pts.final_point <= fin;
        do @(posedge clk); while (pts.ready !== 1'b1);
        items_sent++;
    endtask

    // Hold off input until every predicted word has come, let the block settle, then write the threshold
    task automatic drain_then_write(input logic [31:0] value);
        pts.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] pick_threshold();
        case ($urandom_range(0, 6))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd65536;
            3:       return $urandom;
            4:       return $urandom_range(0, 32'h0004_0000);
            5:       return 32'd1;
            default: return 32'h0000_8000;
        endcase
    endfunction

    // Send one cloud; the style shapes the y values
    task automatic send_cloud(input int unsigned size, input int unsigned style);
        logic [31:0] base;
        logic [31:0] y;
        base = $urandom;
        for (int unsigned k = 0; k < size; k++) begin
            case (style)
                0: y = $urandom;
                1: y = base + ($urandom_range(0, 7) << $urandom_range(12, 18));
                2: y = base + $urandom_range(0, 3) * 32'd65536;
                default:
                    case ($urandom_range(0, 4))
                        0:       y = 32'h8000_0000;
                        1:       y = 32'h7FFF_FFFF;
                        2:       y = 32'd0;
                        3:       y = 32'hFFFF_FFFF;
                        default: y = $urandom;
                    endcase
            endcase
            send_point($urandom, y, $urandom, 24'($urandom), k == size - 1);
        end
    endtask

    // Result side: stall at random, with calm stretches
    initial
    begin
        bit          calm;
        int unsigned left;
        int unsigned gap;
        res.ready = 1'b0;
        calm      = 1'b0;
        left      = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            gap = pace(calm, left);
            if (gap != 0) begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (res.valid !== 1'b1);
        end
    end

    // Stimulus and verdict
    initial
    begin
        int unsigned cloud_idx;
        int unsigned size;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        pts.valid       = 1'b0;
        pts.x_pos       = '0;
        pts.y_pos       = '0;
        pts.z_pos       = '0;
        pts.color       = '0;
        pts.final_point = 1'b0;
        items_sent      = 0;
        cycle_count     = 0;
        send_calm       = 1'b0;
        send_left       = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-point cloud at field extremes, reset threshold
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF, 1'b1);

        // extremes of y, ties, a step equal to and one above the threshold
        send_point(32'd1, 32'h7FFF_FFFF, 32'd0,        24'h00_0000, 1'b0);
        send_point(32'd2, 32'h8000_0000, 32'hFFFF_FFFF, 24'h12_3456, 1'b0);
        send_point(32'd3, 32'h8000_0000, 32'h7FFF_FFFF, 24'hAB_CDEF, 1'b0);
        send_point(32'd4, 32'd0,         32'd0,        24'h00_0000, 1'b0);
        send_point(32'd5, 32'h0001_0000, 32'h5555_5555, 24'h55_5555, 1'b0);
        send_point(32'd6, 32'h0002_0001, 32'hAAAA_AAAA, 24'hAA_AAAA, 1'b0);
        send_point(32'd7, 32'h0001_0000, 32'h0000_0001, 24'h80_0001, 1'b1);

        // full-range y step against the largest threshold
        drain_then_write(32'hFFFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 24'h00_0000, 1'b0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'd9, 24'hFF_FFFF, 1'b1);

        // zero threshold: equal y stays in one region, any step splits
        drain_then_write(32'd0);
        send_point(32'd10, 32'd5, 32'd1, 24'h00_00FF, 1'b0);
        send_point(32'd11, 32'd5, 32'd2, 24'h00_FF00, 1'b0);
        send_point(32'd12, 32'd5, 32'd3, 24'hFF_0000, 1'b0);
        send_point(32'd13, 32'd6, 32'd4, 24'h01_0101, 1'b1);

        // random clouds: mostly small, at least one full, at least one past capacity
        cloud_idx = 0;
        while (items_sent < TEST_ITEMS) begin
            if (cloud_idx == 3) begin
                drain_then_write(32'd0);
                send_cloud(MAX_POINTS, 0);
            end
            else begin
                if (cloud_idx == 7)
                    size = MAX_POINTS + 1;
                else if ($urandom_range(0, 24) == 0)
                    size = $urandom_range(20, MAX_POINTS + 6);
                else
                    size = $urandom_range(1, 12);
                if ($urandom_range(0, 2) == 0)
                    drain_then_write(pick_threshold());
                send_cloud(size, $urandom_range(0, 3));
            end
            cloud_idx++;
        end

        // drain and decide
        pts.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[segment_points_by_y_gap_top.f]
hw/rtl/sypg_pkg.sv
hw/rtl/sypg_if.sv
hw/rtl/sypg_cell.sv
hw/rtl/segment_points_by_y_gap_top.sv
hw/rtl/sypg_checker.sv
sim/sypg_segment_checker.sv
sim/tb_top.sv
